// ===== sv/hba_pkg.sv =====
// hba_pkg: shared types, sizes and constants for the histogram bin accumulator
// used by every module of the block except the generic ram
`default_nettype none

package hba_pkg;

  localparam int NUM_BINS     = 128;
  localparam int NUM_CHANNELS = 4;
  localparam int COUNT_WIDTH  = 32;

  localparam int TOTAL_BINS = NUM_CHANNELS * NUM_BINS;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int SLOT_W     = $clog2(TOTAL_BINS);
  localparam int EPOCH_W    = 32;
  localparam int MEM_W      = EPOCH_W + COUNT_WIDTH;

  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam logic [OUTQ_PTR_W:0] OUTQ_FULL = (OUTQ_PTR_W + 1)'(OUTQ_DEPTH);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EDGE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BINS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALTED      = 3'd4;

  localparam logic [31:0] LEFT_EDGE_RESET   = 32'hFFFE_E667;
  localparam logic [31:0] BIN_SCALE_RESET   = 32'd3276800;
  localparam logic [7:0]  ACTIVE_BINS_RESET = 8'd100;
  localparam logic [31:0] MIN_RESET         = 32'h7FFF_FFFF;
  localparam logic [31:0] MAX_RESET         = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] left_edge;
    logic [31:0] bin_scale;
    logic [7:0]  active_bins;
    logic        accumulate;
    logic        halted;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [31:0]       sample;
    logic              first;
    logic              hit;
    logic [BIN_W-1:0]  bin;
    logic [SLOT_W-1:0] slot;
  } item_t;

  typedef struct packed {
    logic [6:0]  bin_index;
    logic        in_range;
    logic [31:0] bin_count;
    logic [31:0] peak_count;
    logic [31:0] frame_min;
    logic [31:0] frame_max;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/histogram_bin_accumulator.sv =====
// Per-channel uniform-bin histogram engine. Each input beat carries a signed
// Q16.16 sample, a channel and a first-of-frame mark; each yields one output beat
// with the bin, in-range flag, new bin count, peak count and frame min/max.
// One sample is taken per clock while in_stall is low: the bin math is a four-stage
// pipeline and the count update is one read-modify-write of a count ram with one read
// and one write port, with the previous beat's write forwarded. in_stall also rises
// once eight beats are accepted and not yet delivered, so a held output stalls the
// input after eight beats.
// A frame clear is done by bumping an epoch tag kept with each count, so the ram
// needs no clearing pass for it. After reset the count ram is swept once over all
// entries (channels times bins), while in_stall is high; config writes still land.
// Depends on hba_pkg, hba_front, hba_update, hba_outq, hba_ram.
`default_nettype none

module histogram_bin_accumulator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [hba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                      cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [31:0]               sample,
  input  wire logic [1:0]                       channel,
  input  wire logic                             first_of_frame,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [6:0]                            bin_index,
  output logic                                  in_range,
  output logic [31:0]                           bin_count,
  output logic [31:0]                           peak_count,
  output logic signed [31:0]                    frame_min,
  output logic signed [31:0]                    frame_max
);
  import hba_pkg::*;

  cfg_t                cfg;
  item_t               item;
  res_t                res;
  res_t                dout;
  logic                res_valid;
  logic                busy;
  logic                take;
  logic                give;
  logic [OUTQ_PTR_W:0] inflight;

  assign take     = in_valid && !in_stall;
  assign give     = out_valid && !out_stall;
  assign in_stall = busy || (inflight == OUTQ_FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_edge   <= LEFT_EDGE_RESET;
      cfg.bin_scale   <= BIN_SCALE_RESET;
      cfg.active_bins <= ACTIVE_BINS_RESET;
      cfg.accumulate  <= 1'b0;
      cfg.halted      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LEFT_EDGE:   cfg.left_edge   <= cfg_data;
        CFG_BIN_SCALE:   cfg.bin_scale   <= cfg_data;
        CFG_ACTIVE_BINS: cfg.active_bins <= cfg_data[7:0];
        CFG_ACCUMULATE:  cfg.accumulate  <= cfg_data[0];
        CFG_HALTED:      cfg.halted      <= cfg_data[0];
        default:         cfg             <= cfg;
      endcase
    end
  end

  // beats accepted but not yet delivered, bounded by the queue depth
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({take, give})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
    end
  end

  hba_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .take           (take),
    .sample         (sample),
    .channel        (channel),
    .first_of_frame (first_of_frame),
    .item           (item)
  );

  hba_update u_update (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  hba_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .dout      (dout)
  );

  assign bin_index  = dout.bin_index;
  assign in_range   = dout.in_range;
  assign bin_count  = dout.bin_count;
  assign peak_count = dout.peak_count;
  assign frame_min  = dout.frame_min;
  assign frame_max  = dout.frame_max;

endmodule

`default_nettype wire

// ===== sv/hba_ram.sv =====
// hba_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module hba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/hba_front.sv =====
// hba_front: bin computation pipeline, difference, magnitude, product, rounding
// depends on hba_pkg
`default_nettype none

module hba_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire hba_pkg::cfg_t       cfg,
  input  wire logic                take,
  input  wire logic signed [31:0]  sample,
  input  wire logic [1:0]          channel,
  input  wire logic                first_of_frame,
  output hba_pkg::item_t           item
);
  import hba_pkg::*;

  logic               v1;
  logic [31:0]        sample1;
  logic [1:0]         ch1;
  logic               first1;
  logic signed [32:0] diff1;

  logic               v2;
  logic [31:0]        sample2;
  logic [1:0]         ch2;
  logic               first2;
  logic               neg2;
  logic [32:0]        mag2;

  logic               v3;
  logic [31:0]        sample3;
  logic [1:0]         ch3;
  logic               first3;
  logic               neg3;
  logic [63:0]        prod3;

  logic [64:0]        rnd;
  logic [32:0]        b;
  logic               hit_pos;
  logic               hit_neg;
  logic               ch_ok;
  logic               hit;
  logic [BIN_W-1:0]   bin;
  logic [SLOT_W-1:0]  slot;

  always_comb begin
    rnd     = {1'b0, prod3} + 65'h0_8000_0000;
    b       = rnd[64:32];
    hit_pos = (b < 33'(cfg.active_bins)) && (b < 33'(NUM_BINS));
    hit_neg = (prod3 <= 64'h8000_0000) && (cfg.active_bins != 8'd0);
    ch_ok   = 32'(ch3) < NUM_CHANNELS;
    hit     = ch_ok && (neg3 ? hit_neg : hit_pos);
    bin     = (hit && !neg3) ? BIN_W'(b) : '0;
    slot    = SLOT_W'(ch3) * SLOT_W'(NUM_BINS) + SLOT_W'(bin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      item.valid <= 1'b0;
    end else begin
      v1         <= take;
      v2         <= v1;
      v3         <= v2;
      item.valid <= v3;
    end

    sample1 <= sample;
    ch1     <= channel;
    first1  <= first_of_frame;
    diff1   <= {sample[31], sample} - {cfg.left_edge[31], cfg.left_edge};

    sample2 <= sample1;
    ch2     <= ch1;
    first2  <= first1;
    neg2    <= diff1[32];
    mag2    <= diff1[32] ? 33'(-diff1) : 33'(diff1);

    sample3 <= sample2;
    ch3     <= ch2;
    first3  <= first2;
    neg3    <= neg2;
    // magnitude tops out at 2^32 - 1, so the high bit is never set here
    prod3   <= mag2[32] ? {cfg.bin_scale, 32'h0} : (64'(mag2[31:0]) * 64'(cfg.bin_scale));

    item.sample <= sample3;
    item.first  <= first3;
    item.hit    <= hit;
    item.bin    <= bin;
    item.slot   <= slot;
  end

endmodule

`default_nettype wire

// ===== sv/hba_update.sv =====
// hba_update: count memory read-modify-write with forwarding, epoch frame clear,
// peak and frame min/max tracking, clearing pass after reset; depends on hba_pkg, hba_ram
`default_nettype none

module hba_update (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire hba_pkg::cfg_t  cfg,
  input  wire hba_pkg::item_t item,
  output logic                busy,
  output logic                res_valid,
  output hba_pkg::res_t       res
);
  import hba_pkg::*;

  item_t                  s5;
  logic [SLOT_W-1:0]      clr_ptr;
  logic [EPOCH_W-1:0]     epoch;
  logic [EPOCH_W-1:0]     epoch_next;
  logic [COUNT_WIDTH-1:0] peak;
  logic [COUNT_WIDTH-1:0] peak_next;
  logic [COUNT_WIDTH-1:0] peak_base;
  logic [31:0]            run_min;
  logic [31:0]            run_min_next;
  logic [31:0]            run_max;
  logic [31:0]            run_max_next;
  logic [31:0]            min_base;
  logic [31:0]            max_base;

  logic                   lw_valid;
  logic [SLOT_W-1:0]      lw_addr;
  logic [MEM_W-1:0]       lw_data;

  logic [MEM_W-1:0]       rdata;
  logic [MEM_W-1:0]       word;
  logic [MEM_W-1:0]       wdata;
  logic                   we;
  logic [SLOT_W-1:0]      waddr;
  logic [COUNT_WIDTH-1:0] stored;
  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH-1:0] incr;
  logic                   upd;
  logic                   clr;

  hba_ram #(
    .WIDTH (MEM_W),
    .DEPTH (TOTAL_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (item.slot),
    .rdata (rdata)
  );

  always_comb begin
    upd    = s5.valid && !cfg.halted && !busy;
    clr    = upd && s5.first && !cfg.accumulate;
    // previous beat wrote this entry after the read was issued
    word   = (lw_valid && (lw_addr == s5.slot)) ? lw_data : rdata;
    // entries tagged with an older epoch were cleared by a frame start
    stored = (word[MEM_W-1 -: EPOCH_W] == epoch) ? word[COUNT_WIDTH-1:0] : '0;
    base   = clr ? '0 : stored;
    incr   = (&base) ? base : base + 1'b1;
    epoch_next = clr ? epoch + 1'b1 : epoch;

    peak_base = clr ? '0 : peak;
    peak_next = peak_base;
    if (upd && s5.hit && (incr > peak_base)) begin
      peak_next = incr;
    end

    min_base = (upd && s5.first) ? MIN_RESET : run_min;
    max_base = (upd && s5.first) ? MAX_RESET : run_max;
    run_min_next = min_base;
    run_max_next = max_base;
    if (upd && ($signed(s5.sample) < $signed(min_base))) begin
      run_min_next = s5.sample;
    end
    if (upd && ($signed(s5.sample) > $signed(max_base))) begin
      run_max_next = s5.sample;
    end

    we    = busy || (upd && s5.hit);
    waddr = busy ? clr_ptr : s5.slot;
    wdata = busy ? '0 : {epoch_next, incr};
  end

  always_comb begin
    res_valid      = s5.valid;
    res.bin_index  = 7'(s5.bin);
    res.in_range   = s5.hit;
    res.bin_count  = s5.hit ? (upd ? 32'(incr) : 32'(stored)) : 32'h0;
    res.peak_count = 32'(peak_next);
    res.frame_min  = run_min_next;
    res.frame_max  = run_max_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5.valid <= 1'b0;
      busy     <= 1'b1;
      clr_ptr  <= '0;
      epoch    <= '0;
      peak     <= '0;
      run_min  <= MIN_RESET;
      run_max  <= MAX_RESET;
      lw_valid <= 1'b0;
    end else begin
      s5 <= item;
      if (busy) begin
        clr_ptr <= clr_ptr + 1'b1;
        if (clr_ptr == SLOT_W'(TOTAL_BINS - 1)) begin
          busy <= 1'b0;
        end
      end
      epoch    <= epoch_next;
      peak     <= peak_next;
      run_min  <= run_min_next;
      run_max  <= run_max_next;
      lw_valid <= we && !busy;
    end
    lw_addr <= waddr;
    lw_data <= wdata;
  end

endmodule

`default_nettype wire

// ===== sv/hba_outq.sv =====
// hba_outq: result queue between the update stage and the output channel
// depends on hba_pkg
`default_nettype none

module hba_outq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire hba_pkg::res_t din,
  input  wire logic          out_stall,
  output logic               out_valid,
  output hba_pkg::res_t      dout
);
  import hba_pkg::*;

  res_t                  q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic [OUTQ_PTR_W:0]   count;
  logic                  pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign dout      = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      q[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== dv/histogram_checker.sv =====
`timescale 1ns / 1ps
// histogram_checker: watches the register port and both beat channels of the
// histogram bin accumulator, predicts each result and compares it field by field.
// Depends on hba_pkg for sizes, register indexes, reset values and the result type.

module histogram_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [hba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [31:0]                   sample,
  input  logic [1:0]                    channel,
  input  logic                          first_of_frame,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [6:0]                    bin_index,
  input  logic                          in_range,
  input  logic [31:0]                   bin_count,
  input  logic [31:0]                   peak_count,
  input  logic [31:0]                   frame_min,
  input  logic [31:0]                   frame_max,
  output int                            mismatches,
  output int                            pending,
  output int                            results_checked
);
  import hba_pkg::*;

  localparam int PRINT_CAP = 40;

  logic [31:0]            left_edge_q;
  logic [31:0]            bin_scale_q;
  logic [7:0]             active_bins_q;
  logic                   accumulate_q;
  logic                   halted_q;
  logic [COUNT_WIDTH-1:0] bin_counts [TOTAL_BINS];
  logic [COUNT_WIDTH-1:0] peak_q;
  logic [31:0]            frame_min_q;
  logic [31:0]            frame_max_q;
  res_t                   expected_results [$];

  function automatic logic locate_bin(input logic [31:0] s, output logic [BIN_W-1:0] b);
    longint     diff;
    logic [64:0] mag;
    logic [64:0] prod;
    logic [64:0] rounded;
    int          lim;
    lim = (active_bins_q > NUM_BINS) ? NUM_BINS : int'(active_bins_q);
    diff = longint'($signed(s)) - longint'($signed(left_edge_q));
    b = '0;
    if (diff < 0) begin
      // negative side only reaches bin zero when the product is at most one half
      mag = 65'(-diff);
      prod = mag * 65'(bin_scale_q);
      return (prod <= 65'h8000_0000) && (lim > 0);
    end
    mag = 65'(diff);
    prod = mag * 65'(bin_scale_q);
    rounded = (prod + 65'h8000_0000) >> 32;
    if (rounded >= 65'(lim)) return 1'b0;
    b = rounded[BIN_W-1:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("chk: %s mismatch at result %0d: got %h expected %h",
               what, results_checked, got, want);
    mismatches++;
  endtask

  task automatic predict_histogram_update(input logic [31:0] s, input logic [1:0] ch,
                                          input logic f);
    res_t             r;
    logic             hit;
    logic [BIN_W-1:0] b;
    logic [SLOT_W-1:0] slot;
    hit = locate_bin(s, b);
    slot = {ch, b};
    if (!halted_q) begin
      if (f) begin
        frame_min_q = MIN_RESET;
        frame_max_q = MAX_RESET;
        if (!accumulate_q) begin
          foreach (bin_counts[i]) bin_counts[i] = '0;
          peak_q = '0;
        end
      end
      if ($signed(s) < $signed(frame_min_q)) frame_min_q = s;
      if ($signed(s) > $signed(frame_max_q)) frame_max_q = s;
      if (hit) begin
        if (bin_counts[slot] != '1) bin_counts[slot]++;
        if (bin_counts[slot] > peak_q) peak_q = bin_counts[slot];
      end
    end
    r.bin_index  = 7'(b);
    r.in_range   = hit;
    r.bin_count  = hit ? 32'(bin_counts[slot]) : 32'd0;
    r.peak_count = 32'(peak_q);
    r.frame_min  = frame_min_q;
    r.frame_max  = frame_max_q;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic compare_result();
    res_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected beat", bin_count, 32'd0);
      return;
    end
    want = expected_results.pop_front();
    if (bin_index != want.bin_index)
      report_mismatch("bin_index", 32'(bin_index), 32'(want.bin_index));
    if (in_range != want.in_range)
      report_mismatch("in_range", 32'(in_range), 32'(want.in_range));
    if (bin_count != want.bin_count)   report_mismatch("bin_count", bin_count, want.bin_count);
    if (peak_count != want.peak_count) report_mismatch("peak_count", peak_count, want.peak_count);
    if (frame_min != want.frame_min)   report_mismatch("frame_min", frame_min, want.frame_min);
    if (frame_max != want.frame_max)   report_mismatch("frame_max", frame_max, want.frame_max);
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      left_edge_q   = LEFT_EDGE_RESET;
      bin_scale_q   = BIN_SCALE_RESET;
      active_bins_q = ACTIVE_BINS_RESET;
      accumulate_q  = 1'b0;
      halted_q      = 1'b0;
      foreach (bin_counts[i]) bin_counts[i] = '0;
      peak_q        = '0;
      frame_min_q   = MIN_RESET;
      frame_max_q   = MAX_RESET;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_LEFT_EDGE:   left_edge_q = cfg_data;
          CFG_BIN_SCALE:   bin_scale_q = cfg_data;
          CFG_ACTIVE_BINS: active_bins_q = cfg_data[7:0];
          CFG_ACCUMULATE:  accumulate_q = cfg_data[0];
          CFG_HALTED:      halted_q = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_histogram_update(sample, channel, first_of_frame);
      if (out_valid && !out_stall) compare_result();
    end
    pending = expected_results.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for the histogram bin accumulator, directed corner
// beats then random frames under three idling patterns; depends on hba_pkg,
// the block itself and histogram_checker, which predicts and compares results.

module tb_top;
  import hba_pkg::*;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 20;
  localparam int SETTLE_CYCLES    = 8;
  localparam int RANDOM_PER_PHASE = 300;
  localparam int SEGMENT          = 50;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [31:0]   sample = '0;
  logic [1:0]           channel = '0;
  logic                 first_of_frame = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [6:0]           bin_index;
  logic                 in_range;
  logic [31:0]          bin_count;
  logic [31:0]          peak_count;
  logic signed [31:0]   frame_min;
  logic signed [31:0]   frame_max;

  int          mismatches;
  int          pending;
  int          results_checked;
  int          send_idle_pct = 20;
  int          recv_idle_pct = 56;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  logic        in_taken = 1'b0;
  int          quiet_cycles = 0;
  int          beats_sent = 0;
  int          frame_starts = 0;
  int          reg_writes = 0;
  logic [31:0] cur_left = LEFT_EDGE_RESET;
  logic [31:0] cur_scale = BIN_SCALE_RESET;
  int          cur_limit = 100;

  histogram_bin_accumulator dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .channel(channel), .first_of_frame(first_of_frame),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_index(bin_index), .in_range(in_range), .bin_count(bin_count),
    .peak_count(peak_count), .frame_min(frame_min), .frame_max(frame_max)
  );

  histogram_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .channel(channel), .first_of_frame(first_of_frame),
    .out_valid(out_valid), .out_stall(out_stall),
    .bin_index(bin_index), .in_range(in_range), .bin_count(bin_count),
    .peak_count(peak_count), .frame_min(frame_min), .frame_max(frame_max),
    .mismatches(mismatches), .pending(pending), .results_checked(results_checked)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall && !rst;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired with %0d results outstanding", pending);
      $display("tb: failure");
      $finish;
    end
  end

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    reg_writes++;
    case (idx)
      CFG_LEFT_EDGE:   cur_left = data;
      CFG_BIN_SCALE:   cur_scale = data;
      CFG_ACTIVE_BINS: cur_limit = (data[7:0] > NUM_BINS) ? NUM_BINS : int'(data[7:0]);
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic [31:0] s, input logic [1:0] ch, input logic f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    sample = s;
    channel = ch;
    first_of_frame = f;
    in_valid = 1'b1;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
    beats_sent++;
    if (f) frame_starts++;
  endtask

  task automatic random_config();
    logic [31:0] le;
    logic [31:0] bs;
    logic [31:0] ab;
    case ($urandom_range(3))
      0: le = 32'h8000_0000;
      1: le = 32'h7FFF_FFFF;
      2: le = $urandom();
      default: le = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
    endcase
    case ($urandom_range(4))
      0: bs = $urandom();
      1: bs = $urandom_range(1, 64) << 16;
      2: bs = $urandom_range(0, 32'h1_0000);
      3: bs = 32'hFFFF_FFFF;
      default: bs = $urandom_range(1, 4) << 20;
    endcase
    case ($urandom_range(7))
      0: ab = 32'd0;
      1: ab = 32'd1;
      2: ab = 32'd128;
      3: ab = 32'd255;
      default: ab = $urandom_range(2, 127) | ($urandom() & 32'hFFFF_FF00);
    endcase
    wait_idle();
    write_reg(CFG_LEFT_EDGE, le);
    write_reg(CFG_BIN_SCALE, bs);
    write_reg(CFG_ACTIVE_BINS, ab);
    write_reg(CFG_ACCUMULATE, $urandom() & 32'hFFFF_FFFE | 32'($urandom_range(1)));
    write_reg(CFG_HALTED, ($urandom() & 32'hFFFF_FFFE) | 32'($urandom_range(5) == 0));
  endtask

  // mostly samples over the bins in use, some anywhere in the full range
  function automatic logic [31:0] pick_sample();
    longint span;
    longint off;
    longint val;
    if ($urandom_range(9) < 3 || cur_scale == 0) return $urandom();
    span = ((longint'(cur_limit) + 1) << 32) / longint'(cur_scale);
    if (span > (longint'(1) << 33)) span = longint'(1) << 33;
    off = longint'({$urandom(), $urandom()} >> 1) % (span + 1);
    val = longint'($signed(cur_left)) - span / 16 + off;
    if (val > 64'sh7FFF_FFFF) val = 64'sh7FFF_FFFF;
    if (val < -64'sh8000_0000) val = -64'sh8000_0000;
    return val[31:0];
  endfunction

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // reset settings: bin width 0.02 from about -1.1
    send_beat(LEFT_EDGE_RESET, 2'd0, 1'b1);
    send_beat(LEFT_EDGE_RESET - 32'd1, 2'd1, 1'b0);
    send_beat(32'h0000_0000, 2'd2, 1'b0);
    send_beat(32'h7FFF_FFFF, 2'd3, 1'b0);
    send_beat(32'h8000_0000, 2'd0, 1'b0);
    send_beat(LEFT_EDGE_RESET, 2'd0, 1'b0);
    send_beat(LEFT_EDGE_RESET + 32'd129761, 2'd1, 1'b0);
    send_beat(LEFT_EDGE_RESET + 32'd131072, 2'd1, 1'b0);

    // unit bins from zero: rounding ties, oversized active_bins, accumulate
    wait_idle();
    write_reg(CFG_LEFT_EDGE, 32'h0000_0000);
    write_reg(CFG_BIN_SCALE, 32'h0001_0000);
    write_reg(CFG_ACTIVE_BINS, 32'd255);
    write_reg(CFG_ACCUMULATE, 32'd1);
    send_beat(32'hFFFF_8000, 2'd2, 1'b1);
    send_beat(32'hFFFF_7FFF, 2'd2, 1'b0);
    send_beat(32'h0000_8000, 2'd3, 1'b0);
    send_beat(32'h007F_0000, 2'd3, 1'b0);
    send_beat(32'h007F_7FFF, 2'd3, 1'b0);
    send_beat(32'h007F_8000, 2'd3, 1'b0);

    // halted: frame start and samples leave the state alone
    wait_idle();
    write_reg(CFG_HALTED, 32'd1);
    send_beat(32'h0000_0000, 2'd0, 1'b1);
    send_beat(32'h0000_8000, 2'd1, 1'b0);
    wait_idle();
    write_reg(CFG_HALTED, 32'd0);

    // no bins in use, zero scale, full scale, extreme edges
    write_reg(CFG_ACTIVE_BINS, 32'd0);
    send_beat(32'h0000_0000, 2'd1, 1'b0);
    wait_idle();
    write_reg(CFG_BIN_SCALE, 32'h0000_0000);
    write_reg(CFG_LEFT_EDGE, 32'h7FFF_FFFF);
    write_reg(CFG_ACTIVE_BINS, 32'd1);
    write_reg(CFG_ACCUMULATE, 32'd0);
    send_beat(32'h8000_0000, 2'd2, 1'b1);
    send_beat(32'h7FFF_FFFF, 2'd3, 1'b0);
    wait_idle();
    write_reg(CFG_BIN_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_LEFT_EDGE, 32'h8000_0000);
    send_beat(32'h8000_0000, 2'd0, 1'b0);
    send_beat(32'h8000_0001, 2'd1, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 20; recv_idle_pct = 56; end
        1: begin send_idle_pct = 56; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % SEGMENT == 0) random_config();
        if (phase == 2 && n == SEGMENT / 2) hold_req = 1'b1;
        send_beat(pick_sample(), 2'($urandom_range(3)), $urandom_range(24) == 0);
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("tb: %0d sample beats over three idling patterns, %0d results checked",
             beats_sent, results_checked);
    $display("tb: %0d frame starts, %0d register writes, %0d mismatches",
             frame_starts, reg_writes, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
